// File: sv/assert_macros.svh
// Assertion helpers; every use samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define AST_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define AST_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/rmu_pkg.sv
package rmu_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CMP,
        ST_MRD0,
        ST_MRD1,
        ST_MFIN
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_scan;
        logic shift;
        logic insert;
        logic rd_mid;
        logic rd_lo;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic pos_zero;
        logic greater;
    } stat_t;

endpackage

// File: sv/rmu_ctrl.sv
module rmu_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rmu_pkg::stat_t stat,
    output rmu_pkg::cmd_t  cmd,
    output logic          busy
);
    import rmu_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.full || stat.pos_zero)
                begin
                    state_next = ST_MRD0;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = stat.greater ? ST_SCAN : ST_MRD0;
            end
            ST_MRD0: state_next = ST_MRD1;
            ST_MRD1: state_next = ST_MFIN;
            ST_MFIN: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:
            begin
                if (!stat.full)
                begin
                    cmd.insert  = stat.pos_zero;
                    cmd.rd_scan = !stat.pos_zero;
                end
            end
            ST_CMP:
            begin
                cmd.shift  = stat.greater;
                cmd.insert = !stat.greater;
            end
            ST_MRD0: cmd.rd_mid = 1'b1;
            ST_MRD1: cmd.rd_lo  = 1'b1;
            ST_MFIN: cmd.finish = 1'b1;
            default: busy = 1'b0;
        endcase
    end

`include "assert_macros.svh"
    `AST_IMPLY(a_one_cmd, 1'b1, $onehot0(cmd))
    `AST_NEXT(a_start_busy, start && !busy, busy)
    `AST_IMPLY(a_no_insert_full, cmd.insert, !stat.full)
endmodule

// File: sv/rmu_datapath.sv
module rmu_datapath #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rmu_pkg::cmd_t      cmd,
    input  logic signed [31:0] sample_value,
    input  logic               restart,
    output rmu_pkg::stat_t     stat,
    output logic               done,
    output logic signed [31:0] median_floor,
    output logic               median_has_half,
    output logic [8:0]         held_count,
    output logic               overflow
);
    import rmu_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VALUE_BITS-1:0] mem [CAPACITY];
    logic signed [VALUE_BITS-1:0] v_reg;
    logic signed [VALUE_BITS-1:0] rd_data_reg;
    logic signed [VALUE_BITS-1:0] hi_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                cnt_eff;
    logic [CW-1:0]                mid;
    logic [AW-1:0]                pos_reg;
    logic                         ovf_reg;
    logic                         done_reg;
    logic signed [31:0]           med_reg;
    logic                         half_reg;
    logic                         ovf_out_reg;
    logic [AW-1:0]                rd_addr;
    logic                         rd_en;
    logic signed [VALUE_BITS:0]   sum;
    logic signed [VALUE_BITS-1:0] med_calc;

    assign cnt_eff = restart ? '0 : count_reg;
    assign mid     = count_reg >> 1;
    assign sum     = (VALUE_BITS+1)'(hi_reg) + (VALUE_BITS+1)'(rd_data_reg);
    assign med_calc = count_reg[0] ? hi_reg : VALUE_BITS'(sum >>> 1);

    assign stat.full     = ovf_reg;
    assign stat.pos_zero = (pos_reg == '0);
    assign stat.greater  = (rd_data_reg > v_reg);

    always_comb
    begin
        rd_en   = cmd.rd_scan || cmd.rd_mid || cmd.rd_lo;
        rd_addr = pos_reg - AW'(1);
        if (cmd.rd_mid)
        begin
            rd_addr = mid[AW-1:0];
        end
        else if (cmd.rd_lo)
        begin
            rd_addr = mid[AW-1:0] - AW'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.load)
        begin
            count_next = cnt_eff;
        end
        else if (cmd.insert)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            mem[pos_reg] <= v_reg;
        end
        else if (cmd.shift)
        begin
            mem[pos_reg] <= rd_data_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg   <= sample_value[VALUE_BITS-1:0];
            pos_reg <= cnt_eff[AW-1:0];
        end
        else if (cmd.shift)
        begin
            pos_reg <= pos_reg - AW'(1);
        end
        if (cmd.rd_lo)
        begin
            hi_reg <= rd_data_reg;
        end
        if (cmd.finish)
        begin
            med_reg     <= 32'(med_calc);
            half_reg    <= !count_reg[0] && sum[0];
            ovf_out_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.finish;
            if (cmd.load)
            begin
                ovf_reg <= (cnt_eff >= CW'(CAPACITY));
            end
        end
    end

    assign done            = done_reg;
    assign median_floor    = med_reg;
    assign median_has_half = half_reg;
    assign held_count      = 9'(count_reg);
    assign overflow        = ovf_out_reg;

`include "assert_macros.svh"
    `AST_ALWAYS(a_count_cap, count_reg <= CW'(CAPACITY))
    `AST_IMPLY(a_shift_pos, cmd.shift, pos_reg != '0)
    `AST_NEXT(a_done_pulse, done_reg, !done_reg)
endmodule

// File: sv/running_median_unit.sv
// Running median of a stream of signed samples.
// Input: drive sample_value and restart with start high; the item is taken at a
// rising edge where start is high and busy is low. restart empties the store
// before the sample goes in.
// Output: done is high for exactly one cycle with median_floor, median_has_half,
// held_count and overflow valid in that cycle; the receiver cannot stall.
// Sequence: after the accepting edge the unit walks down the single-port sorted
// store, reading each held value greater than the sample and moving it up one
// place, until it meets a value that is not greater or reaches the bottom, and
// writes the sample there (a full store skips the walk). It then does two store
// reads for the middle values and a final step to form the result.
// busy falls in the done cycle, so the next item can be taken there.
// A full store drops the sample and reports overflow with the old median.
// Reset empties the store (held count zero); store contents need no clearing.
module running_median_unit #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] sample_value,
    input  logic               restart,
    output logic               done,
    output logic signed [31:0] median_floor,
    output logic               median_has_half,
    output logic [8:0]         held_count,
    output logic               overflow
);
    import rmu_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rmu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rmu_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sample_value    (sample_value),
        .restart         (restart),
        .stat            (stat),
        .done            (done),
        .median_floor    (median_floor),
        .median_has_half (median_has_half),
        .held_count      (held_count),
        .overflow        (overflow)
    );
endmodule
